// ===== rtl/core/note_onset_offset_tracker_top_defines.svh =====
// Assertion macros shared by the note tracker RTL.
// Every property is sampled on the rising edge of clk_i and is switched off while rst_ni is low.
`ifndef NOTE_ONSET_OFFSET_TRACKER_TOP_DEFINES_SVH
`define NOTE_ONSET_OFFSET_TRACKER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NOOT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NOOT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/noot_pkg.sv =====
`timescale 1ns / 1ps

package noot_pkg;

  // Field widths of the beats.
  localparam int TimeW    = 32;
  localparam int CfgAddrW = 4;
  localparam int CfgDataW = 32;

  // Operation codes of an input beat.
  typedef enum logic [1:0] {
    OpEvidence = 2'd0,
    OpTurnOn   = 2'd1,
    OpTurnOff  = 2'd2
  } op_e;

  // Register indexes on the configuration port.
  typedef enum logic [1:0] {
    RegFirstMidi   = 2'd0,
    RegSlotsInUse  = 2'd1,
    RegMaxGap      = 2'd2,
    RegMinDuration = 2'd3
  } cfg_reg_e;

  // Reset values of the configuration registers.
  localparam logic [6:0]       FirstMidiRst   = 7'd21;
  localparam logic [6:0]       SlotsInUseRst  = 7'd64;
  localparam logic [TimeW-1:0] MaxGapRst      = 32'd4;
  localparam logic [TimeW-1:0] MinDurationRst = 32'd2;

  typedef struct packed {
    logic [1:0]       operation;
    logic [5:0]       slot_index;
    logic [TimeW-1:0] current_time;
    logic [TimeW-1:0] onset_candidate_time;
  } in_item_t;

  typedef struct packed {
    logic [7:0]       key_number;
    logic [TimeW-1:0] note_start;
    logic [TimeW-1:0] note_end;
    logic [6:0]       polyphony_after;
    logic             last;
  } out_item_t;

  // Configuration as seen by the tracking logic.
  typedef struct packed {
    logic [6:0]       first_midi_note;
    logic [6:0]       slots_in_use;
    logic [TimeW-1:0] max_gap;
    logic [TimeW-1:0] min_duration;
  } cfg_t;

endpackage

// ===== rtl/core/noot_ram.sv =====
`timescale 1ns / 1ps

module noot_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                          rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; the data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/noot_cfg.sv =====
`timescale 1ns / 1ps

module noot_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [noot_pkg::CfgAddrW-1:0] paddr,
  input  logic [noot_pkg::CfgDataW-1:0] pwdata,
  output logic [noot_pkg::CfgDataW-1:0] prdata,
  output logic                          pready,
  output noot_pkg::cfg_t                cfg_o
);

  import noot_pkg::*;

  cfg_t     cfg_q;
  cfg_t     cfg_d;
  cfg_reg_e sel;
  logic     wr_en;

  assign pready = 1'b1;
  assign sel    = cfg_reg_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  // Register writes.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (sel)
        RegFirstMidi:   cfg_d.first_midi_note = pwdata[6:0];
        RegSlotsInUse:  cfg_d.slots_in_use    = pwdata[6:0];
        RegMaxGap:      cfg_d.max_gap         = pwdata[TimeW-1:0];
        RegMinDuration: cfg_d.min_duration    = pwdata[TimeW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.first_midi_note <= FirstMidiRst;
      cfg_q.slots_in_use    <= SlotsInUseRst;
      cfg_q.max_gap         <= MaxGapRst;
      cfg_q.min_duration    <= MinDurationRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read-back.
  always_comb begin
    case (sel)
      RegFirstMidi:   prdata = CfgDataW'(cfg_q.first_midi_note);
      RegSlotsInUse:  prdata = CfgDataW'(cfg_q.slots_in_use);
      RegMaxGap:      prdata = CfgDataW'(cfg_q.max_gap);
      RegMinDuration: prdata = CfgDataW'(cfg_q.min_duration);
      default:        prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/core/note_onset_offset_tracker_top.sv =====
`timescale 1ns / 1ps
// Note onset/offset tracker. The block keeps up to MAX_SLOTS note slots, each holding an on/off
// flag and an evidence flag in flip-flops, and its latest evidence time and onset time in two
// simple dual-port synchronous memories. An evidence beat (operation 0) is taken without
// stalling the input. A turn-on or turn-off beat walks the tracked slots
// (slots_in_use, limited to MAX_SLOTS) in ascending order, one slot per cycle through the
// memory read ports, and it holds the input stalled until the walk and its final record are
// done; the walk pauses while the result side stalls and a note record is waiting to
// leave. With no tracked slots such a beat is taken like an evidence beat. Note records are
// held back by one so that the final record of a beat carries last; a turn-off beat that
// finishes no reportable note produces no output beat. The memories need no clearing after
// reset: the times of a slot are used only once they have been written.
`include "note_onset_offset_tracker_top_defines.svh"

module note_onset_offset_tracker_top #(
  parameter int MAX_SLOTS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  noot_pkg::in_item_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output noot_pkg::out_item_t           out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [noot_pkg::CfgAddrW-1:0] paddr,
  input  logic [noot_pkg::CfgDataW-1:0] pwdata,
  output logic [noot_pkg::CfgDataW-1:0] prdata,
  output logic                          pready
);

  import noot_pkg::*;

  localparam int IdxW  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int PolyW = $clog2(MAX_SLOTS + 1);

  typedef enum logic [2:0] {
    StIdle  = 3'b001,
    StScan  = 3'b010,
    StDrain = 3'b100
  } state_e;

  cfg_t             cfg;
  state_e           state_q, state_d;
  logic [1:0]       op_q;
  logic [TimeW-1:0] now_q;
  logic [TimeW-1:0] onset_q;
  logic [IdxW-1:0]  iss_q, iss_d;
  logic             iss_done_q, iss_done_d;
  logic             s1_vld_q, s1_vld_d;
  logic [IdxW-1:0]  s1_idx_q, s1_idx_d;
  logic             slot_on_q [MAX_SLOTS];
  logic             seen_q [MAX_SLOTS];
  logic             rd_on_q;
  logic             rd_seen_q;
  logic [PolyW-1:0] poly_q, poly_d;
  logic [PolyW-1:0] poly_dec;
  logic [7:0]       poly_ext;
  logic             pend_vld_q, pend_vld_d;
  out_item_t        pend_q, pend_d;
  logic             out_vld_q, out_vld_d;
  out_item_t        out_q, out_d;

  logic             in_acc;
  logic [7:0]       n_slots;
  logic [7:0]       last_idx;
  logic             scan_op;
  logic             ev_we;
  logic [IdxW-1:0]  ev_waddr;
  logic [TimeW-1:0] ev_rdata;
  logic [TimeW-1:0] on_rdata;
  logic             on_we;
  logic             rd_issue;
  logic             adv;
  logic             s1_step;
  logic             cur_on;
  logic             cur_seen;
  logic [TimeW-1:0] gap;
  logic [TimeW-1:0] dur;
  logic             turn_on;
  logic             turn_off;
  logic             report;
  logic             out_free;
  logic             push_mid;
  logic             push_fin;
  out_item_t        rec;

  // Configuration registers.
  noot_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Number of tracked slots, limited to the size of the table.
  assign n_slots  = (8'(cfg.slots_in_use) > 8'(MAX_SLOTS)) ? 8'(MAX_SLOTS)
                                                            : 8'(cfg.slots_in_use);
  assign last_idx = n_slots - 8'd1;

  // Input handshake and evidence writes.
  assign in_stall_o = (state_q != StIdle);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign scan_op    = (in_data_i.operation == OpTurnOn) || (in_data_i.operation == OpTurnOff);
  assign ev_we      = in_acc && (in_data_i.operation == OpEvidence)
                      && (8'(in_data_i.slot_index) < n_slots);
  assign ev_waddr   = IdxW'(in_data_i.slot_index);

  noot_ram #(
    .Width (TimeW),
    .Depth (MAX_SLOTS)
  ) u_ev_ram (
    .clk_i   (clk_i),
    .we_i    (ev_we),
    .waddr_i (ev_waddr),
    .wdata_i (in_data_i.current_time),
    .re_i    (rd_issue),
    .raddr_i (iss_q),
    .rdata_o (ev_rdata)
  );

  noot_ram #(
    .Width (TimeW),
    .Depth (MAX_SLOTS)
  ) u_on_ram (
    .clk_i   (clk_i),
    .we_i    (on_we),
    .waddr_i (s1_idx_q),
    .wdata_i (onset_q),
    .re_i    (rd_issue),
    .raddr_i (iss_q),
    .rdata_o (on_rdata)
  );

  // Evaluation of the slot whose memory data has just arrived.
  assign cur_on   = rd_on_q;
  assign cur_seen = rd_seen_q;
  assign gap      = now_q - ev_rdata;
  assign dur      = ev_rdata - on_rdata;
  assign turn_on  = (op_q == OpTurnOn) && !cur_on && cur_seen && (ev_rdata == now_q);
  assign turn_off = (op_q == OpTurnOff) && cur_on && (now_q > ev_rdata)
                    && (gap > cfg.max_gap);
  assign report   = turn_off && (ev_rdata >= on_rdata) && (dur >= cfg.min_duration);

  // Polyphony after this slot turns off, saturated for the output field.
  assign poly_dec = (poly_q != '0) ? (poly_q - PolyW'(1)) : poly_q;
  assign poly_ext = 8'(poly_dec);

  always_comb begin
    rec                 = '0;
    rec.key_number      = 8'(cfg.first_midi_note) + 8'(s1_idx_q);
    rec.note_start      = on_rdata;
    rec.note_end        = ev_rdata;
    rec.polyphony_after = poly_ext[7] ? 7'd127 : poly_ext[6:0];
    rec.last            = 1'b0;
  end

  // The walk halts only when a new record must displace the held one and the output is full.
  assign out_free = !out_vld_q || !out_stall_i;
  assign adv      = !(s1_vld_q && report && pend_vld_q && !out_free);
  assign rd_issue = (state_q == StScan) && !iss_done_q && adv;
  assign s1_step  = s1_vld_q && adv;
  assign on_we    = s1_step && turn_on;
  assign push_mid = s1_step && report && pend_vld_q;
  assign push_fin = (state_q == StDrain) && pend_vld_q && out_free;

  // Sequencer.
  always_comb begin
    state_d    = state_q;
    iss_d      = iss_q;
    iss_done_d = iss_done_q;
    s1_vld_d   = s1_vld_q;
    s1_idx_d   = s1_idx_q;
    case (state_q)
      StIdle: begin
        if (in_acc && scan_op && (n_slots != 8'd0)) begin
          state_d    = StScan;
          iss_d      = '0;
          iss_done_d = 1'b0;
        end
      end
      StScan: begin
        if (adv) begin
          s1_vld_d = rd_issue;
          if (rd_issue) begin
            s1_idx_d = iss_q;
          end
        end
        if (rd_issue) begin
          if (8'(iss_q) == last_idx) begin
            iss_done_d = 1'b1;
          end else begin
            iss_d = iss_q + IdxW'(1);
          end
        end
        if (iss_done_q && !s1_vld_q) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        if (!pend_vld_q || out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Polyphony count, held record and output register.
  always_comb begin
    poly_d = poly_q;
    if (s1_step && turn_on) begin
      poly_d = poly_q + PolyW'(1);
    end else if (s1_step && turn_off) begin
      poly_d = poly_dec;
    end

    pend_vld_d = pend_vld_q;
    pend_d     = pend_q;
    if (s1_step && report) begin
      pend_vld_d = 1'b1;
      pend_d     = rec;
    end else if (push_fin) begin
      pend_vld_d = 1'b0;
    end

    out_vld_d = out_vld_q && out_stall_i;
    out_d     = out_q;
    if (push_mid) begin
      out_vld_d = 1'b1;
      out_d     = pend_q;
    end else if (push_fin) begin
      out_vld_d = 1'b1;
      out_d      = pend_q;
      out_d.last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      iss_done_q <= 1'b0;
      s1_vld_q   <= 1'b0;
      poly_q     <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      iss_done_q <= iss_done_d;
      s1_vld_q   <= s1_vld_d;
      poly_q     <= poly_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // Payload registers; the slot flags are read alongside the memories.
  always_ff @(posedge clk_i) begin
    iss_q    <= iss_d;
    s1_idx_q <= s1_idx_d;
    pend_q   <= pend_d;
    out_q    <= out_d;
    if (in_acc) begin
      op_q    <= in_data_i.operation;
      now_q   <= in_data_i.current_time;
      onset_q <= in_data_i.onset_candidate_time;
    end
    if (rd_issue) begin
      rd_on_q   <= slot_on_q[iss_q];
      rd_seen_q <= seen_q[iss_q];
    end
  end

  // Per-slot on and evidence flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_SLOTS; i++) begin
        slot_on_q[i] <= 1'b0;
        seen_q[i]    <= 1'b0;
      end
    end else begin
      if (s1_step && turn_on) begin
        slot_on_q[s1_idx_q] <= 1'b1;
      end else if (s1_step && turn_off) begin
        slot_on_q[s1_idx_q] <= 1'b0;
      end
      if (ev_we) begin
        seen_q[ev_waddr] <= 1'b1;
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // A slot that turns off must have been counted.
  `NOOT_ASSERT_IMP(a_poly_nonzero, s1_step && turn_off, poly_q != '0,
                   "slot turned off while the polyphony count is zero")
  // The read pipeline only carries data during a walk.
  `NOOT_ASSERT_IMP(a_s1_in_scan, s1_vld_q, state_q == StScan,
                   "slot evaluation stage valid outside a walk")
  // No record is left behind once the block is idle.
  `NOOT_ASSERT_IMP(a_pend_idle, state_q == StIdle, !pend_vld_q,
                   "note record still held while idle")
  // The final record of a beat ends the beat.
  `NOOT_ASSERT_NXT(a_last_ends, push_fin, state_q == StIdle,
                   "walk did not end after the final record")

endmodule

// ===== dv/note_onset_offset_tracker_top_tb.sv =====
`timescale 1ns / 1ps

module note_onset_offset_tracker_top_tb;
  import noot_pkg::*;

  localparam int MAX_SLOTS = 64;
  // Operation code left unused by the block.
  localparam logic [1:0] OpUnused = 2'd3;
  // Extra wait once every predicted record has been seen, before the next test step.
  localparam int SETTLE_CYCLES = 80;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int WATCHDOG_LIMIT = 4000;

  logic                clk_i;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  in_item_t            in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_item_t           out_data_o;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [CfgAddrW-1:0] paddr       = '0;
  logic [CfgDataW-1:0] pwdata      = '0;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  // Shadow of the configuration registers.
  logic [6:0]       cfg_first_midi = FirstMidiRst;
  logic [6:0]       cfg_slots      = SlotsInUseRst;
  logic [TimeW-1:0] cfg_max_gap    = MaxGapRst;
  logic [TimeW-1:0] cfg_min_dur    = MinDurationRst;

  // Expected state of the slot table.
  bit               slot_on   [MAX_SLOTS];
  bit               ev_seen   [MAX_SLOTS];
  logic [TimeW-1:0] ev_time   [MAX_SLOTS];
  logic [TimeW-1:0] start_time[MAX_SLOTS];
  int               polyphony = 0;

  out_item_t pending_notes[$];
  int        mismatches    = 0;

  // Traffic knobs and the state of the random note generator.
  int               in_idle_pct   = 0;
  int               out_stall_pct = 0;
  int               holdoff_left  = 0;
  bit               sounding[MAX_SLOTS];
  logic [TimeW-1:0] tick = 32'd1000;

  note_onset_offset_tracker_top #(
    .MAX_SLOTS(MAX_SLOTS)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(negedge clk_i) begin
    if (holdoff_left > 0) begin
      out_stall_i <= 1'b1;
      holdoff_left--;
    end else begin
      out_stall_i <= ($urandom_range(99) < out_stall_pct);
    end
  end

  // Ends the run when nothing moves on any port for too long.
  always @(posedge clk_i) begin : watchdog
    int quiet_cycles;
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (psel && penable)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog expired after %0d quiet cycles", quiet_cycles);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Each accepted note record is compared with the oldest one predicted.
  always @(posedge clk_i) begin : check_notes
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_notes.size() == 0) begin
        if (mismatches < 10) begin
          $display("Unexpected note record: key %0d start %0d end %0d poly %0d last %0b",
                   out_data_o.key_number, out_data_o.note_start, out_data_o.note_end,
                   out_data_o.polyphony_after, out_data_o.last);
        end
        mismatches++;
      end else begin
        want = pending_notes.pop_front();
        if (out_data_o.key_number !== want.key_number ||
            out_data_o.note_start !== want.note_start ||
            out_data_o.note_end !== want.note_end ||
            out_data_o.polyphony_after !== want.polyphony_after ||
            out_data_o.last !== want.last) begin
          if (mismatches < 10) begin
            $display("Note record mismatch at %0t:", $realtime);
            $display("  expected key %0d start %0d end %0d poly %0d last %0b",
                     want.key_number, want.note_start, want.note_end,
                     want.polyphony_after, want.last);
            $display("  got key %0d start %0d end %0d poly %0d last %0b",
                     out_data_o.key_number, out_data_o.note_start, out_data_o.note_end,
                     out_data_o.polyphony_after, out_data_o.last);
          end
          mismatches++;
        end
      end
    end
  end

  // Applies one accepted beat to the expected slot table and queues the note records it ends.
  task automatic advance_slot_table(in_item_t b);
    int               n;
    out_item_t        rec;
    out_item_t        recs[$];
    logic [TimeW-1:0] ev;
    logic [TimeW-1:0] gap;
    n = (cfg_slots > MAX_SLOTS) ? MAX_SLOTS : int'(cfg_slots);
    case (b.operation)
      OpEvidence: begin
        if (int'(b.slot_index) < n) begin
          ev_time[b.slot_index] = b.current_time;
          ev_seen[b.slot_index] = 1'b1;
        end
      end
      OpTurnOn: begin
        for (int i = 0; i < n; i++) begin
          if (!slot_on[i] && ev_seen[i] && ev_time[i] == b.current_time) begin
            slot_on[i]    = 1'b1;
            start_time[i] = b.onset_candidate_time;
            polyphony++;
          end
        end
      end
      OpTurnOff: begin
        for (int i = 0; i < n; i++) begin
          if (slot_on[i]) begin
            ev  = ev_time[i];
            gap = (b.current_time > ev) ? b.current_time - ev : '0;
            if (gap > cfg_max_gap) begin
              slot_on[i] = 1'b0;
              if (polyphony > 0) polyphony--;
              // A note whose evidence lies before its onset is never reported.
              if (ev >= start_time[i] && ev - start_time[i] >= cfg_min_dur) begin
                rec.key_number      = 8'(cfg_first_midi) + 8'(i);
                rec.note_start      = start_time[i];
                rec.note_end        = ev;
                rec.polyphony_after = (polyphony > 127) ? 7'd127 : 7'(polyphony);
                rec.last            = 1'b0;
                recs.push_back(rec);
              end
            end
          end
        end
        if (recs.size() > 0) recs[recs.size() - 1].last = 1'b1;
        foreach (recs[k]) pending_notes.push_back(recs[k]);
      end
      default: ;
    endcase
  endtask

  function automatic in_item_t beat_of(logic [1:0] op, logic [5:0] slot,
                                       logic [TimeW-1:0] now, logic [TimeW-1:0] onset);
    in_item_t b;
    b.operation            = op;
    b.slot_index           = slot;
    b.current_time         = now;
    b.onset_candidate_time = onset;
    return b;
  endfunction

  // Offers one beat after a random idle gap; returns at the edge that accepted it.
  task automatic send_beat(in_item_t b);
    @(negedge clk_i);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    advance_slot_table(b);
  endtask

  // Drops valid and waits for every predicted record, then for extra cycles.
  task automatic settle_block(int extra);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_notes.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e r, logic [CfgDataW-1:0] v);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (r)
      RegFirstMidi:   cfg_first_midi = v[6:0];
      RegSlotsInUse:  cfg_slots      = v[6:0];
      RegMaxGap:      cfg_max_gap    = v;
      RegMinDuration: cfg_min_dur    = v;
      default: ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Frames of music: sounding slots send evidence, then turn-on and turn-off beats follow,
  // with some stray and malformed beats mixed in.
  task automatic run_frames(int beats);
    int       sent;
    int       n;
    in_item_t noise;
    sent = 0;
    while (sent < beats) begin
      n = (cfg_slots > MAX_SLOTS) ? MAX_SLOTS : int'(cfg_slots);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(99) < 15) sounding[i] = !sounding[i];
        if (sounding[i] && $urandom_range(99) < 85) begin
          send_beat(beat_of(OpEvidence, 6'(i), ($urandom_range(19) == 0) ? tick + 1 : tick,
                            $urandom));
          sent++;
        end
      end
      if ($urandom_range(19) == 0) begin
        send_beat(beat_of(OpEvidence, 6'($urandom_range(63)), tick, $urandom));
        sent++;
      end
      if ($urandom_range(9) != 0) begin
        send_beat(beat_of(OpTurnOn, 6'($urandom), tick,
                          ($urandom_range(19) == 0) ? $urandom : tick - $urandom_range(2)));
        sent++;
      end
      if ($urandom_range(9) != 0) begin
        send_beat(beat_of(OpTurnOff, 6'($urandom), tick, $urandom));
        sent++;
      end
      if ($urandom_range(9) == 0) begin
        noise = beat_of(2'($urandom_range(3)), 6'($urandom), $urandom, $urandom);
        send_beat(noise);
        if (noise.operation != OpUnused) sent++;
      end
      if ($urandom_range(29) == 0) settle_block(0);
      tick += $urandom_range(1, 3);
    end
  endtask

  task automatic random_config();
    write_reg(RegFirstMidi, $urandom_range(127));
    write_reg(RegSlotsInUse, ($urandom_range(3) == 0) ? 64 : $urandom_range(4, 16));
    write_reg(RegMaxGap, $urandom_range(6));
    write_reg(RegMinDuration, $urandom_range(5));
  endtask

  // Notes switched on and off at reset settings, with time extremes, a turn-on without
  // evidence, evidence later than the current time and onsets later than the evidence.
  task automatic test_basic_notes();
    send_beat(beat_of(OpUnused, 6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_beat(beat_of(OpTurnOn, 6'd0, 32'd0, 32'd0));
    send_beat(beat_of(OpEvidence, 6'd0, 32'd10, 32'd0));
    send_beat(beat_of(OpEvidence, 6'd63, 32'd10, 32'd0));
    send_beat(beat_of(OpEvidence, 6'd5, 32'd10, 32'd0));
    send_beat(beat_of(OpTurnOn, 6'd0, 32'd10, 32'd8));
    send_beat(beat_of(OpEvidence, 6'd0, 32'd12, 32'd0));
    send_beat(beat_of(OpEvidence, 6'd63, 32'd20, 32'd0));
    send_beat(beat_of(OpEvidence, 6'd9, 32'd30, 32'd0));
    send_beat(beat_of(OpTurnOn, 6'd0, 32'd30, 32'd40));
    send_beat(beat_of(OpTurnOff, 6'd0, 32'd17, 32'd0));
    send_beat(beat_of(OpTurnOff, 6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_beat(beat_of(OpEvidence, 6'd1, 32'd0, 32'd0));
    send_beat(beat_of(OpTurnOn, 6'd0, 32'd0, 32'd0));
    send_beat(beat_of(OpEvidence, 6'd1, 32'hFFFF_FFFF, 32'd0));
    send_beat(beat_of(OpEvidence, 6'd2, 32'd50, 32'd0));
    send_beat(beat_of(OpTurnOn, 6'd0, 32'd50, 32'hFFFF_FFFF));
    send_beat(beat_of(OpTurnOff, 6'd0, 32'd0, 32'd0));
  endtask

  // Register extremes: untracked slots, a slot left on above the tracked range, no slots
  // at all, an oversized slot count and the widest gap and duration.
  task automatic test_register_edges();
    settle_block(SETTLE_CYCLES);
    send_beat(beat_of(OpEvidence, 6'd40, 32'd100, 32'd0));
    send_beat(beat_of(OpEvidence, 6'd3, 32'd100, 32'd0));
    send_beat(beat_of(OpTurnOn, 6'd0, 32'd100, 32'd100));
    settle_block(SETTLE_CYCLES);
    write_reg(RegFirstMidi, 127);
    write_reg(RegSlotsInUse, 8);
    write_reg(RegMaxGap, 0);
    write_reg(RegMinDuration, 0);
    send_beat(beat_of(OpEvidence, 6'd40, 32'd200, 32'd0));
    send_beat(beat_of(OpTurnOff, 6'd0, 32'd101, 32'd0));
    settle_block(SETTLE_CYCLES);
    write_reg(RegSlotsInUse, 0);
    send_beat(beat_of(OpEvidence, 6'd0, 32'd5, 32'd0));
    send_beat(beat_of(OpTurnOn, 6'd0, 32'd5, 32'd5));
    send_beat(beat_of(OpTurnOff, 6'd0, 32'd300, 32'd0));
    settle_block(SETTLE_CYCLES);
    write_reg(RegSlotsInUse, 127);
    write_reg(RegMaxGap, 32'hFFFF_FFFF);
    write_reg(RegMinDuration, 32'hFFFF_FFFF);
    send_beat(beat_of(OpTurnOff, 6'd0, 32'hFFFF_FFFF, 32'd0));
    settle_block(SETTLE_CYCLES);
    write_reg(RegMaxGap, 0);
    send_beat(beat_of(OpTurnOff, 6'd0, 32'hFFFF_FFFF, 32'd0));
  endtask

  // The receiver holds off for a long stretch while beats keep coming, so the block fills.
  task automatic test_backpressure();
    settle_block(SETTLE_CYCLES);
    write_reg(RegFirstMidi, 0);
    write_reg(RegSlotsInUse, 12);
    write_reg(RegMaxGap, 1);
    write_reg(RegMinDuration, 1);
    tick += 100;
    run_frames(20);
    holdoff_left = HOLDOFF_CYCLES;
    run_frames(30);
  endtask

  // Random traffic in each idling regime, each with its own settings.
  task automatic test_random_traffic();
    int idle_pct[4];
    int stall_pct[4];
    idle_pct  = '{0, 83, 0, 23};
    stall_pct = '{0, 0, 83, 23};
    for (int p = 0; p < 4; p++) begin
      settle_block(SETTLE_CYCLES);
      random_config();
      in_idle_pct   = idle_pct[p];
      out_stall_pct = stall_pct[p];
      tick += 100;
      run_frames(90);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_basic_notes();
    test_register_edges();
    test_backpressure();
    test_random_traffic();
    settle_block(SETTLE_CYCLES);
    if (mismatches == 0 && pending_notes.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/noot_pkg.sv
rtl/core/noot_ram.sv
rtl/core/noot_cfg.sv
rtl/core/note_onset_offset_tracker_top.sv
dv/note_onset_offset_tracker_top_tb.sv
